[src/prox_pkg.sv]
// Package for the proximity change trigger: field widths, limits and status codes.
package prox_pkg;

    // Field widths
    localparam int unsigned DIST_W     = 14;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned MM_W       = 11;
    localparam int unsigned COOL_W     = 24;
    localparam int unsigned MOOD_W     = 11;
    localparam int unsigned STATUS_W   = 3;

    // Packed stream widths, rounded up to whole bytes
    localparam int unsigned S_DATA_W   = 48;
    localparam int unsigned M_DATA_W   = 24;

    // Configuration port
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_COOLDOWN  = 1'b1;

    // Register reset values
    localparam logic [MM_W-1:0]   THRESHOLD_RST = 11'd300;
    localparam logic [COOL_W-1:0] COOLDOWN_RST  = 24'd30000;

    // Sample filter limits in mm
    localparam logic [MM_W-1:0] GLASS_LIMIT_MM = 11'd60;
    localparam logic [MM_W-1:0] RANGE_LIMIT_MM = 11'd2000;

    // Mood curve: 2*mm - 2000, clamped to +/-1000
    localparam logic [MM_W-1:0]        MOOD_LOW_MM  = 11'd500;
    localparam logic [MM_W-1:0]        MOOD_HIGH_MM = 11'd1500;
    localparam logic signed [12:0]     MOOD_OFFSET  = 13'sd2000;
    localparam logic signed [MOOD_W-1:0] MOOD_FULL  = 11'sd1000;

    // Drift: new = old + floor((sample - old) / 50). The difference is biased
    // by +2000 into 0..4000, divided by 50 with a reciprocal multiply
    // (ceil(2^17 / 50), exact below 4681), then the bias of 40 is removed.
    localparam logic [11:0] DRIFT_BIAS  = 12'd2000;
    localparam logic [11:0] DRIFT_RECIP = 12'd2622;
    localparam int unsigned DRIFT_SHIFT = 17;
    localparam logic [6:0]  DRIFT_QBIAS = 7'd40;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GLASS     = 3'd0,
        ST_RANGE     = 3'd1,
        ST_BUSY      = 3'd2,
        ST_SEEDED    = 3'd3,
        ST_TRACKED   = 3'd4,
        ST_TRIGGERED = 3'd5,
        ST_DONE      = 3'd6
    } status_t;

endpackage

[src/proximity_change_trigger.sv]
// Proximity change trigger: sample filter, baseline tracker and trigger logic.
//
// Channel   Dir  Contents (low bit first)
// s_axis    in   tdata: distance_mm[13:0], now_ms[45:14]; tuser: op
// m_axis    out  tdata: trigger[0], mood_milli[11:1], baseline_mm[22:12]; tuser: status
// apb       in   threshold_mm at 0x0, cooldown_ms at 0x4
//
// One item per cycle sustained while m_tready stays high. Each item passes
// through the input register, is evaluated against the tracker state, and
// its result is registered at the same edge that updates the state.
// A stalled result holds the input register; s_tready drops only when both
// stages are full and m_tready is low. Reset clears the state and restores
// the register defaults.
module proximity_change_trigger (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [prox_pkg::S_DATA_W-1:0]       s_tdata,   // distance_mm, now_ms, pad
    input  logic                                s_tuser,   // op

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [prox_pkg::M_DATA_W-1:0]       m_tdata,   // trigger, mood_milli, baseline_mm, pad
    output logic [prox_pkg::STATUS_W-1:0]       m_tuser,   // status

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prox_pkg::ADDR_W-1:0]         paddr,
    input  logic [prox_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [prox_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // Configuration registers
    logic [prox_pkg::MM_W-1:0]   threshold_reg;
    logic [prox_pkg::COOL_W-1:0] cooldown_reg;

    // Tracker state
    logic [prox_pkg::MM_W-1:0]   baseline_reg, baseline_next;
    logic                        base_valid_reg, base_valid_next;
    logic                        busy_reg, busy_next;
    logic [prox_pkg::TIME_W-1:0] cool_start_reg, cool_start_next;
    logic                        cool_armed_reg, cool_armed_next;

    // Input stage
    logic                        in_valid_reg;
    logic                        op_reg;
    logic signed [prox_pkg::DIST_W-1:0] dist_reg;
    logic [prox_pkg::TIME_W-1:0] now_reg;

    // Result stage
    logic                        out_valid_reg;
    prox_pkg::status_t           status_reg, status_next;
    logic                        trig_reg, trig_next;
    logic signed [prox_pkg::MOOD_W-1:0] mood_reg, mood_next;

    logic advance;
    logic apb_write;

    // Evaluation signals
    logic [prox_pkg::MM_W-1:0]   mm;
    logic                        is_neg, is_glass, is_far;
    logic                        cooling;
    logic [prox_pkg::TIME_W-1:0] elapsed;
    logic signed [12:0]          diff;
    logic [prox_pkg::MM_W-1:0]   delta;
    logic [11:0]                 biased;
    logic [23:0]                 drift_prod;
    logic [6:0]                  drift_q;
    logic [11:0]                 drift_sum;
    logic signed [12:0]          mood_lin;

    // Handshakes
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign pready   = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    // Register readback
    always_comb begin
        prdata = '0;
        case (paddr[2])
            prox_pkg::REG_THRESHOLD: prdata[prox_pkg::MM_W-1:0]   = threshold_reg;
            prox_pkg::REG_COOLDOWN:  prdata[prox_pkg::COOL_W-1:0] = cooldown_reg;
            default:                 prdata = '0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= prox_pkg::THRESHOLD_RST;
            cooldown_reg  <= prox_pkg::COOLDOWN_RST;
        end else if (apb_write) begin
            case (paddr[2])
                prox_pkg::REG_THRESHOLD: threshold_reg <= pwdata[prox_pkg::MM_W-1:0];
                prox_pkg::REG_COOLDOWN:  cooldown_reg  <= pwdata[prox_pkg::COOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser;
            dist_reg <= s_tdata[prox_pkg::DIST_W-1:0];
            now_reg  <= s_tdata[prox_pkg::DIST_W +: prox_pkg::TIME_W];
        end
    end

    // Sample classification
    assign is_neg   = dist_reg[prox_pkg::DIST_W-1];
    assign is_far   = !is_neg && (dist_reg[prox_pkg::DIST_W-2:prox_pkg::MM_W] != '0
                      || dist_reg[prox_pkg::MM_W-1:0] > prox_pkg::RANGE_LIMIT_MM);
    assign mm       = dist_reg[prox_pkg::MM_W-1:0];
    assign is_glass = !is_neg && dist_reg[prox_pkg::DIST_W-2:prox_pkg::MM_W] == '0
                      && mm < prox_pkg::GLASS_LIMIT_MM;

    // Cooldown window, elapsed time modulo 2^32
    assign elapsed = now_reg - cool_start_reg;
    assign cooling = cool_armed_reg &&
                     (elapsed < {{(prox_pkg::TIME_W-prox_pkg::COOL_W){1'b0}}, cooldown_reg});

    // Step from baseline
    assign diff  = $signed({2'b00, mm}) - $signed({2'b00, baseline_reg});
    assign delta = diff[12] ? prox_pkg::MM_W'(-diff) : diff[prox_pkg::MM_W-1:0];

    // Drift toward the sample by floor(diff / 50)
    assign biased     = diff[11:0] + prox_pkg::DRIFT_BIAS;
    assign drift_prod = biased * prox_pkg::DRIFT_RECIP;
    assign drift_q    = drift_prod[prox_pkg::DRIFT_SHIFT +: 7];
    assign drift_sum  = {1'b0, baseline_reg} + {5'd0, drift_q} - {5'd0, prox_pkg::DRIFT_QBIAS};

    // Mood: linear 2*mm - 2000 between the clamp points
    assign mood_lin = $signed({1'b0, mm, 1'b0}) - prox_pkg::MOOD_OFFSET;

    // Per-item evaluation
    always_comb begin
        baseline_next   = baseline_reg;
        base_valid_next = base_valid_reg;
        busy_next       = busy_reg;
        cool_start_next = cool_start_reg;
        cool_armed_next = cool_armed_reg;
        status_next     = prox_pkg::ST_TRACKED;
        trig_next       = 1'b0;
        mood_next       = '0;
        if (op_reg) begin
            busy_next       = 1'b0;
            cool_start_next = now_reg;
            cool_armed_next = 1'b1;
            status_next     = prox_pkg::ST_DONE;
        end else if (is_glass) begin
            status_next = prox_pkg::ST_GLASS;
        end else if (is_neg || is_far) begin
            status_next = prox_pkg::ST_RANGE;
        end else if (busy_reg) begin
            status_next = prox_pkg::ST_BUSY;
        end else if (!base_valid_reg) begin
            baseline_next   = mm;
            base_valid_next = 1'b1;
            status_next     = prox_pkg::ST_SEEDED;
        end else if (!cooling && delta >= threshold_reg) begin
            trig_next     = 1'b1;
            baseline_next = mm;
            busy_next     = 1'b1;
            status_next   = prox_pkg::ST_TRIGGERED;
            if (mm <= prox_pkg::MOOD_LOW_MM) begin
                mood_next = -prox_pkg::MOOD_FULL;
            end else if (mm >= prox_pkg::MOOD_HIGH_MM) begin
                mood_next = prox_pkg::MOOD_FULL;
            end else begin
                mood_next = mood_lin[prox_pkg::MOOD_W-1:0];
            end
        end else begin
            baseline_next = drift_sum[prox_pkg::MM_W-1:0];
            status_next   = prox_pkg::ST_TRACKED;
        end
    end

    // State and result update when an item moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg   <= '0;
            base_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            cool_start_reg <= '0;
            cool_armed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                baseline_reg   <= baseline_next;
                base_valid_reg <= base_valid_next;
                busy_reg       <= busy_next;
                cool_start_reg <= cool_start_next;
                cool_armed_reg <= cool_armed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            status_reg <= status_next;
            trig_reg   <= trig_next;
            mood_reg   <= mood_next;
        end
    end

    // Result channel; baseline_mm is the tracker state left by this item
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, baseline_reg, mood_reg, trig_reg};

    // Checks
    a_trig_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tuser == prox_pkg::ST_TRIGGERED)
        else $error("trigger set without triggered status");

    a_trig_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg && trig_next |=> busy_reg)
        else $error("busy not set after trigger");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    a_unseeded_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !base_valid_reg |-> baseline_reg == '0)
        else $error("baseline nonzero before seeding");

endmodule
